// File: hw/rtl/ffa_pkg.sv
package ffa_pkg;

  localparam int TableEntries = 32;
  localparam int AddressBits  = 32;

  localparam logic [7:0]  HeaderReset = 8'd8;
  localparam logic [15:0] MinRemReset = 16'd16;

  localparam logic [0:0] CFG_HEADER  = 1'b0;
  localparam logic [0:0] CFG_MIN_REM = 1'b1;

  localparam logic OP_ALLOC  = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  localparam logic [1:0] ST_ALLOCATED = 2'd0;
  localparam logic [1:0] ST_NO_FIT    = 2'd1;
  localparam logic [1:0] ST_INSERTED  = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

endpackage

// File: hw/rtl/ffa_table.sv
module ffa_table #(
  parameter int TABLE_ENTRIES = ffa_pkg::TableEntries,
  parameter int ADDRESS_BITS  = ffa_pkg::AddressBits,
  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  logic                    clk,
  input  logic                    rd_en,
  input  logic [IW-1:0]           rd_idx,
  output logic [ADDRESS_BITS-1:0] rd_addr,
  output logic [31:0]             rd_size,
  input  logic                    wr_en,
  input  logic [IW-1:0]           wr_idx,
  input  logic [ADDRESS_BITS-1:0] wr_addr,
  input  logic [31:0]             wr_size
);

  logic [ADDRESS_BITS+31:0] mem [TABLE_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= {wr_addr, wr_size};
    end
    if (rd_en) begin
      {rd_addr, rd_size} <= mem[rd_idx];
    end
  end

endmodule

// File: hw/rtl/first_fit_free_list_allocator_top.sv
// Each item walks the entry memory from start to out_valid, except an insert into a full
// table, which answers without a walk. The longest item is an allocate that splits and puts
// the leftover back at the front. The search reads one entry at a time (a read state, then a
// check state), and every entry moved takes a read then a write.
// Throughput: one item at a time; busy is high from the cycle after acceptance
// until out_valid rises. The receiver cannot stall. Reset (synchronous, rst_n low) empties
// the table and restores register defaults.
module first_fit_free_list_allocator_top #(
  parameter int TABLE_ENTRIES = ffa_pkg::TableEntries,
  parameter int ADDRESS_BITS  = ffa_pkg::AddressBits,
  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
  localparam int CW = $clog2(TABLE_ENTRIES + 1)
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_operation,
  input  logic [31:0] in_block_address,
  input  logic [31:0] in_size_bytes,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [31:0] out_granted_address,
  output logic [31:0] out_granted_size,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // The sequencer is the only control. Shifting moves entries one slot at a
  // time through the memory: read an entry, then write it to its neighbor.
  typedef enum logic [3:0] {
    S_IDLE, S_SRCH_RD, S_SRCH_CHK, S_INS_POS, S_SHUP_RD, S_SHUP_WR,
    S_INS_WR, S_SHDN_RD, S_SHDN_WR, S_SPLIT, S_DONE
  } state_t;

  state_t state_r;
  logic [7:0]  hdr_r;
  logic [15:0] minrem_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] i_r;
  logic [CW-1:0] pos_r;
  logic        op_r;
  logic [ADDRESS_BITS-1:0] key_addr_r;
  logic [31:0] key_size_r;
  logic [32:0] need_r;
  logic [ADDRESS_BITS-1:0] baddr_r;
  logic [31:0] bsize_r;
  logic        split_r;
  logic [1:0]  st_r;
  logic        ovalid_r;
  // Marks that the current insert pass is the leftover of a split.
  logic        split_pending_r;
  logic [31:0] gaddr_r, gsize_r;
  logic [1:0]  ostat_r;

  logic                    rd_en, wr_en;
  logic [IW-1:0]           rd_idx, wr_idx;
  logic [ADDRESS_BITS-1:0] rd_addr, wr_addr;
  logic [31:0]             rd_size, wr_size;

  ffa_table #(.TABLE_ENTRIES(TABLE_ENTRIES), .ADDRESS_BITS(ADDRESS_BITS)) u_table (
    .clk, .rd_en, .rd_idx, .rd_addr, .rd_size, .wr_en, .wr_idx, .wr_addr, .wr_size
  );

  logic [32:0] rest;
  assign rest = {1'b0, rd_size} - need_r;

  always_comb begin
    rd_en = 1'b0;
    rd_idx = i_r[IW-1:0];
    wr_en = 1'b0;
    wr_idx = i_r[IW-1:0];
    wr_addr = rd_addr;
    wr_size = rd_size;
    unique case (state_r)
      S_SRCH_RD, S_SHDN_RD: rd_en = 1'b1;
      S_SHUP_RD: begin
        rd_en = 1'b1;
        rd_idx = IW'(i_r - CW'(1));
      end
      S_SHUP_WR, S_SHDN_WR: wr_en = 1'b1;
      S_INS_WR: begin
        wr_en = 1'b1;
        wr_idx = pos_r[IW-1:0];
        wr_addr = key_addr_r;
        wr_size = key_size_r;
      end
      default: ;
    endcase
    if (state_r == S_SHDN_WR) wr_idx = IW'(i_r - CW'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      hdr_r <= ffa_pkg::HeaderReset;
      minrem_r <= ffa_pkg::MinRemReset;
      count_r <= '0;
      ovalid_r <= 1'b0;
      split_pending_r <= 1'b0;
    end else begin
      ovalid_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          ffa_pkg::CFG_HEADER:  hdr_r <= cfg_data[7:0];
          ffa_pkg::CFG_MIN_REM: minrem_r <= cfg_data;
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            op_r <= in_operation;
            key_addr_r <= ADDRESS_BITS'(in_block_address);
            key_size_r <= in_size_bytes;
            need_r <= {25'd0, hdr_r} + {1'b0, in_size_bytes};
            split_r <= 1'b0;
            i_r <= '0;
            if (in_operation == ffa_pkg::OP_INSERT &&
                count_r >= CW'(TABLE_ENTRIES)) begin
              st_r <= ffa_pkg::ST_FULL;
              state_r <= S_DONE;
            end else begin
              state_r <= S_SRCH_RD;
            end
          end
        end
        S_SRCH_RD: begin
          if (i_r >= count_r) begin
            if (op_r == ffa_pkg::OP_INSERT) begin
              pos_r <= i_r;
              i_r <= count_r;
              state_r <= S_INS_POS;
            end else begin
              st_r <= ffa_pkg::ST_NO_FIT;
              state_r <= S_DONE;
            end
          end else begin
            state_r <= S_SRCH_CHK;
          end
        end
        S_SRCH_CHK: begin
          if (op_r == ffa_pkg::OP_INSERT) begin
            if (rd_addr >= key_addr_r) begin
              pos_r <= i_r;
              i_r <= count_r;
              state_r <= S_INS_POS;
            end else begin
              i_r <= i_r + CW'(1);
              state_r <= S_SRCH_RD;
            end
          end else if ({1'b0, rd_size} >= need_r) begin
            baddr_r <= rd_addr;
            bsize_r <= rd_size;
            split_r <= ({17'd0, minrem_r} <= rest);
            i_r <= i_r + CW'(1);
            state_r <= S_SHDN_RD;
          end else begin
            i_r <= i_r + CW'(1);
            state_r <= S_SRCH_RD;
          end
        end
        S_INS_POS: state_r <= (i_r > pos_r) ? S_SHUP_RD : S_INS_WR;
        S_SHUP_RD: state_r <= S_SHUP_WR;
        S_SHUP_WR: begin
          i_r <= i_r - CW'(1);
          state_r <= S_INS_POS;
        end
        S_INS_WR: begin
          count_r <= count_r + CW'(1);
          // A leftover reinsert keeps the allocate status set by the split.
          if (!split_pending_r) st_r <= ffa_pkg::ST_INSERTED;
          state_r <= S_DONE;
        end
        S_SHDN_RD: begin
          if (i_r >= count_r) begin
            count_r <= count_r - CW'(1);
            st_r <= ffa_pkg::ST_ALLOCATED;
            state_r <= split_r ? S_SPLIT : S_DONE;
          end else begin
            state_r <= S_SHDN_WR;
          end
        end
        S_SHDN_WR: begin
          i_r <= i_r + CW'(1);
          state_r <= S_SHDN_RD;
        end
        S_SPLIT: begin
          // Reinsert the leftover as an insert, keeping the allocate status.
          key_addr_r <= baddr_r + ADDRESS_BITS'(need_r);
          key_size_r <= bsize_r - need_r[31:0];
          i_r <= '0;
          state_r <= S_SRCH_RD;
          split_r <= 1'b0;
          split_pending_r <= 1'b1;
          op_r <= ffa_pkg::OP_INSERT;
          st_r <= ffa_pkg::ST_ALLOCATED;
        end
        S_DONE: begin
          ovalid_r <= 1'b1;
          split_pending_r <= 1'b0;
          ostat_r <= split_pending_r ? ffa_pkg::ST_ALLOCATED : st_r;
          if (st_r == ffa_pkg::ST_ALLOCATED) begin
            gaddr_r <= 32'(baddr_r);
            gsize_r <= split_pending_r ? need_r[31:0] : bsize_r;
          end else begin
            gaddr_r <= '0;
            gsize_r <= '0;
          end
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy = (state_r != S_IDLE);
  assign out_valid = ovalid_r;
  assign out_status = ostat_r;
  assign out_granted_address = gaddr_r;
  assign out_granted_size = gsize_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_ENTRIES)) else $error("free count beyond table");
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result while busy");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted item did not start");
`endif

endmodule

// File: dv/first_fit_free_list_allocator_top_tb.sv
`timescale 1ns / 100ps

module first_fit_free_list_allocator_top_tb;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] addr;
    logic [31:0] size;
  } grant_t;

  // Golden model of the free-block table, plus the queue of grants it predicts.
  class grant_board;
    logic [31:0] blk_addr[ffa_pkg::TableEntries];
    logic [31:0] blk_size[ffa_pkg::TableEntries];
    int          count;
    logic [7:0]  header;
    logic [15:0] min_rem;
    grant_t      pending[$];
    int          errors;

    function new();
      count = 0;
      header = ffa_pkg::HeaderReset;
      min_rem = ffa_pkg::MinRemReset;
      errors = 0;
    endfunction

    function bit put_block(logic [31:0] a, logic [31:0] s);
      int pos;
      pos = 0;
      if (count >= ffa_pkg::TableEntries) return 0;
      while (pos < count && blk_addr[pos] < a) pos++;
      for (int k = count; k > pos; k--) begin
        blk_addr[k] = blk_addr[k-1];
        blk_size[k] = blk_size[k-1];
      end
      blk_addr[pos] = a;
      blk_size[pos] = s;
      count++;
      return 1;
    endfunction

    // Note one accepted item and predict what it returns.
    function void note_item(logic op, logic [31:0] a, logic [31:0] s);
      grant_t g;
      logic [32:0] need;
      logic [32:0] rest;
      logic [31:0] ba, bs;
      int i;
      g = '0;
      i = 0;
      if (op == ffa_pkg::OP_INSERT) begin
        g.status = put_block(a, s) ? ffa_pkg::ST_INSERTED : ffa_pkg::ST_FULL;
      end else begin
        need = {25'd0, header} + {1'b0, s};
        while (i < count && {1'b0, blk_size[i]} < need) i++;
        if (i >= count) begin
          g.status = ffa_pkg::ST_NO_FIT;
        end else begin
          ba = blk_addr[i];
          bs = blk_size[i];
          rest = {1'b0, bs} - need;
          for (int k = i; k + 1 < count; k++) begin
            blk_addr[k] = blk_addr[k+1];
            blk_size[k] = blk_size[k+1];
          end
          count--;
          g.status = ffa_pkg::ST_ALLOCATED;
          g.addr = ba;
          g.size = bs;
          if (rest >= {17'd0, min_rem}) begin
            void'(put_block(ba + need[31:0], rest[31:0]));
            g.size = need[31:0];
          end
        end
      end
      pending.push_back(g);
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(grant_t got);
      grant_t exp;
      if (pending.size() == 0) begin
        report("result with nothing expected");
        return;
      end
      exp = pending.pop_front();
      if (got.status !== exp.status) report($sformatf("status %0d, want %0d",
                                                       got.status, exp.status));
      if (got.addr !== exp.addr) report($sformatf("address %h, want %h",
                                                   got.addr, exp.addr));
      if (got.size !== exp.size) report($sformatf("size %h, want %h",
                                                   got.size, exp.size));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_operation;
  logic [31:0] in_block_address;
  logic [31:0] in_size_bytes;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [31:0] out_granted_address;
  logic [31:0] out_granted_size;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [15:0] cfg_data;

  grant_board board;
  int         idle_pct;
  int         cycles;
  // Address cursor so that random inserts tend to land near each other.
  logic [31:0] base_addr;

  first_fit_free_list_allocator_top dut (
    .clk, .rst_n, .start, .busy, .in_operation, .in_block_address, .in_size_bytes,
    .out_valid, .out_status, .out_granted_address, .out_granted_size,
    .cfg_we, .cfg_index, .cfg_data
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Results are taken at the edge that ends their one strobed cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      board.check_result('{out_status, out_granted_address, out_granted_size});
    end
  end

  // The run ends here if the block stops answering.
  always @(posedge clk) begin
    cycles++;
    if (cycles > 1500000) begin
      $display("first_fit_free_list_allocator_top_tb: done, errors");
      $finish;
    end
  end

  // Send one item: random idle gap first, then hold start until the block takes it.
  // Start stays high afterwards; the next idle gap or drain() drops it.
  task automatic send_item(logic op, logic [31:0] a, logic [31:0] s);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_operation <= op;
    in_block_address <= a;
    in_size_bytes <= s;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_item(op, a, s);
  endtask

  // Registers change only with the table quiet: wait out every pending result.
  task automatic drain();
    start <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [15:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == ffa_pkg::CFG_HEADER) board.header = val[7:0];
    else board.min_rem = val;
  endtask

  task automatic random_item();
    int r;
    logic [31:0] s;
    r = $urandom_range(99);
    // Mostly modest sizes so allocations keep splitting and refilling the table.
    s = ($urandom_range(9) == 0) ? $urandom() : $urandom_range(600);
    if (r < 5) begin
      send_item(1'($urandom_range(1)), $urandom(), $urandom());
    end else if (r < 50 && board.count < ffa_pkg::TableEntries - 1 || board.count == 0) begin
      base_addr = ($urandom_range(7) == 0) ? $urandom() : base_addr + $urandom_range(512);
      send_item(ffa_pkg::OP_INSERT, base_addr, s);
    end else begin
      send_item(ffa_pkg::OP_ALLOC, $urandom(), $urandom_range(3) == 0 ? s : {24'd0, s[7:0]});
    end
  endtask

  initial begin
    board = new();
    cycles = 0;
    idle_pct = 0;
    base_addr = 32'h1000;
    rst_n = 1'b0;
    start = 1'b0;
    in_operation = ffa_pkg::OP_ALLOC;
    in_block_address = '0;
    in_size_bytes = '0;
    cfg_we = 1'b0;
    cfg_index = ffa_pkg::CFG_HEADER;
    cfg_data = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table, extremes, duplicate addresses, zero sizes, no fit.
    send_item(ffa_pkg::OP_ALLOC, 32'h0, 32'h0);
    send_item(ffa_pkg::OP_INSERT, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
    send_item(ffa_pkg::OP_INSERT, 32'h0000_0100, 32'd0);
    send_item(ffa_pkg::OP_INSERT, 32'h0000_0100, 32'd64);
    send_item(ffa_pkg::OP_INSERT, 32'h0000_0000, 32'd40);
    send_item(ffa_pkg::OP_ALLOC, 32'h0, 32'hFFFF_FFFF);
    send_item(ffa_pkg::OP_ALLOC, 32'h0, 32'd24);
    send_item(ffa_pkg::OP_ALLOC, 32'h0, 32'd30);
    send_item(ffa_pkg::OP_ALLOC, 32'h0, 32'hFFFF_FFF7);
    send_item(ffa_pkg::OP_ALLOC, 32'h0, 32'd100);
    // A zero minimum still splits off an empty leftover.
    write_reg(ffa_pkg::CFG_MIN_REM, 16'd0);
    write_reg(ffa_pkg::CFG_HEADER, 16'd0);
    send_item(ffa_pkg::OP_INSERT, 32'h200, 32'd50);
    send_item(ffa_pkg::OP_ALLOC, 32'h0, 32'd50);
    send_item(ffa_pkg::OP_ALLOC, 32'h0, 32'd0);
    write_reg(ffa_pkg::CFG_HEADER, 16'h00FF);
    write_reg(ffa_pkg::CFG_MIN_REM, 16'hFFFF);
    // Fill the table and overflow it.
    for (int k = 0; k < ffa_pkg::TableEntries + 2; k++) begin
      send_item(ffa_pkg::OP_INSERT, $urandom(), 32'd300);
    end
    send_item(ffa_pkg::OP_ALLOC, 32'h0, 32'd1);

    // Random phases over several register settings, with pending results drained between phases.
    for (int ph = 0; ph < 7; ph++) begin
      idle_pct = (ph < 2) ? 14 : (ph < 4) ? 71 : 0;
      case (ph % 4)
        0: begin
          write_reg(ffa_pkg::CFG_HEADER, {8'd0, ffa_pkg::HeaderReset});
          write_reg(ffa_pkg::CFG_MIN_REM, ffa_pkg::MinRemReset);
        end
        1: begin
          write_reg(ffa_pkg::CFG_HEADER, 16'd0);
          write_reg(ffa_pkg::CFG_MIN_REM, 16'd0);
        end
        2: begin
          write_reg(ffa_pkg::CFG_HEADER, 16'($urandom_range(255)));
          write_reg(ffa_pkg::CFG_MIN_REM, 16'($urandom_range(300)));
        end
        default: begin
          write_reg(ffa_pkg::CFG_HEADER, 16'h00FF);
          write_reg(ffa_pkg::CFG_MIN_REM, 16'hFFFF);
        end
      endcase
      repeat (200) random_item();
    end

    drain();
    repeat (300) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("first_fit_free_list_allocator_top_tb: done, clean");
    end else begin
      $display("first_fit_free_list_allocator_top_tb: done, errors");
    end
    $finish;
  end

endmodule

// File: first_fit_free_list_allocator_top.f
hw/rtl/ffa_pkg.sv
hw/rtl/ffa_table.sv
hw/rtl/first_fit_free_list_allocator_top.sv
dv/first_fit_free_list_allocator_top_tb.sv
